[design/tblp_pkg.sv]
// shared types, constants and helpers of the tx buffer level predictor
package tblp_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W  = 63;
    localparam int RATE_W  = 48;
    localparam int CNT32_W = 32;
    localparam int ACC_W   = 64;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam int IN_W  = 136;
    localparam int OUT_W = 72;

    localparam logic [TIME_W-1:0] T63_MAX = {TIME_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 3'd0,
        OP_PUSH_STRT = 3'd1,
        OP_POP_STRT  = 3'd2,
        OP_PUSH_END  = 3'd3,
        OP_POP_END   = 3'd4,
        OP_QUERY     = 3'd5,
        OP_MEASURE   = 3'd6,
        OP_NONE      = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_SAMPLE_RATE  = 1'b0,
        REG_TARGET_LEVEL = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RET_RD,
        S_RET_CHK,
        S_END_RD,
        S_END_CHK,
        S_MUL,
        S_LVL1,
        S_LVL2,
        S_DIV,
        S_OUT
    } state_t;

    // pointer plus offset, modulo the queue depth (offset below depth)
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
        logic [PTR_W+CNT_W-1:0] sum;
        sum = {{CNT_W{1'b0}}, ptr} + {{PTR_W{1'b0}}, off};
        if (sum >= (PTR_W+CNT_W)'(QUEUE_DEPTH))
            sum = sum - (PTR_W+CNT_W)'(QUEUE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

endpackage

[design/tblp_ram.sv]
// generic single write, single read ram with registered read data
module tblp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/tblp_mul.sv]
// serial q32 multiplier: one 32x32 partial product per cycle, saturated result
module tblp_mul import tblp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  a,
    input  logic [RATE_W-1:0] b,
    output logic              done,
    output logic [ACC_W-1:0]  result
);
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [63:0]  prod_reg, prod_next;
    logic [6:0]   sh_reg, sh_next;
    logic [111:0] acc_reg, acc_next;
    logic [31:0]  a_sel, b_sel;

    always_comb
    begin
        a_sel = cnt_reg[0] ? a[63:32] : a[31:0];
        b_sel = cnt_reg[1] ? {16'd0, b[47:32]} : b[31:0];
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            cnt_next  = 3'd0;
            busy_next = 1'b1;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                prod_next = a_sel * b_sel;
                sh_next   = 7'(32 * (32'(cnt_reg[0]) + 32'(cnt_reg[1])));
            end
            if (cnt_reg != 3'd0)
            begin
                acc_next = acc_reg + ({48'd0, prod_reg} << sh_reg);
            end
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
    end

    assign done   = done_reg;
    assign result = (acc_reg[111:96] != 16'd0) ? {ACC_W{1'b1}} : acc_reg[95:32];
endmodule

[design/tblp_div100.sv]
// divide by one hundred, one 16-bit quotient digit per cycle by reciprocal multiply
module tblp_div100 import tblp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);
    // 2^30 / 100 rounded up, exact for digit steps below 100 * 2^16
    localparam logic [23:0] RECIP   = 24'd10737419;
    localparam logic [22:0] HUNDRED = 23'd100;

    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  rem_reg, rem_next;
    logic [63:0] x_reg, x_next;
    logic [22:0] step;
    logic [46:0] prod;
    logic [15:0] digit;
    logic [22:0] back;

    always_comb
    begin
        // remainder and next dividend digit, quotient digits shift in from the bottom
        step      = {rem_reg, x_reg[63:48]};
        prod      = {24'd0, step} * {23'd0, RECIP};
        digit     = prod[45:30];
        back      = step - {7'd0, digit} * HUNDRED;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        x_next    = x_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            rem_next  = '0;
            x_next    = {1'b0, dividend};
        end
        else if (busy_reg)
        begin
            rem_next = back[6:0];
            x_next   = {x_reg[47:0], digit};
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        x_reg   <= x_next;
    end

    assign done     = done_reg;
    assign quotient = x_reg[TIME_W-1:0];
endmodule

[design/tx_buffer_level_predictor_core.sv]
// top level of the tx buffer level predictor: sequencer, queue rams and arithmetic
// sequence: non-level requests answer in the cycle after acceptance; a level request blocks
// s_tready through S_RET_RD/S_RET_CHK per pair, S_END_RD, S_END_CHK, S_MUL, S_LVL1, S_LVL2,
// S_DIV when a measure moves the bias, and S_OUT; non-level 1 per cycle while output is free
// reset: asynchronous active low clears counts, heads, totals, bias and registers
// queue ram contents stay undefined, entries are only read below the valid count
module tx_buffer_level_predictor_core import tblp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // op[2:0], event_time[65:3], sample_count[97:66], measured_level[129:98], zero pad
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // predicted_level[62:0], start_pending[63], status[65:64], zero pad
    output logic [OUT_W-1:0]   m_tdata,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [RATE_W-1:0]  cfg_wdata
);
    // request fields
    logic [OP_W-1:0]    in_op;
    logic [TIME_W-1:0]  in_time;
    logic [CNT32_W-1:0] in_cnt;
    logic [CNT32_W-1:0] in_meas;

    assign in_op   = s_tdata[2:0];
    assign in_time = s_tdata[65:3];
    assign in_cnt  = s_tdata[97:66];
    assign in_meas = s_tdata[129:98];

    // configuration
    logic [RATE_W-1:0]  rate_reg;
    logic [CNT32_W-1:0] target_reg;

    // state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    scnt_reg, scnt_next, ecnt_reg, ecnt_next;
    logic [PTR_W-1:0]    shead_reg, shead_next, ehead_reg, ehead_next;
    logic [ACC_W-1:0]    blanked_reg, blanked_next;
    logic [TIME_W-1:0]   fst_reg, fst_next;
    logic                fseen_reg, fseen_next;
    logic [ACC_W-1:0]    sent_reg, sent_next;
    logic [ACC_W-1:0]    bias_reg, bias_next;

    // working request
    logic                meas_op_reg, meas_op_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [CNT32_W-1:0]  meas_reg, meas_next;
    logic [ACC_W-1:0]    stream_reg, stream_next;
    logic [ACC_W-1:0]    pred_reg, pred_next;
    logic                zero_reg, zero_next;
    logic [TIME_W-1:0]   level_reg, level_next;
    logic                neg_reg, neg_next;

    // output register
    logic                ovalid_reg, ovalid_next;
    logic [TIME_W-1:0]   olevel_reg, olevel_next;
    logic                opend_reg, opend_next;
    logic [STAT_W-1:0]   ostat_reg, ostat_next;

    // rams
    logic                s_we, e_we;
    logic [PTR_W-1:0]    s_waddr, e_waddr, s_raddr, e_raddr;
    logic [TIME_W-1:0]   s_rdata, e_rdata;

    // serial units
    logic                mul_start, mul_done, div_start, div_done;
    logic [ACC_W-1:0]    consumed;
    logic [TIME_W-1:0]   div_q;
    logic [TIME_W-1:0]   div_dividend_next, div_dividend_reg;

    logic                out_free;
    logic [ACC_W-1:0]    a_val;
    logic [ACC_W:0]      sum65;
    logic [ACC_W-1:0]    res;
    logic [ACC_W-1:0]    mag;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        scnt_next    = scnt_reg;
        ecnt_next    = ecnt_reg;
        shead_next   = shead_reg;
        ehead_next   = ehead_reg;
        blanked_next = blanked_reg;
        fst_next     = fst_reg;
        fseen_next   = fseen_reg;
        sent_next    = sent_reg;
        bias_next    = bias_reg;
        meas_op_next = meas_op_reg;
        t_next       = t_reg;
        meas_next    = meas_reg;
        stream_next  = stream_reg;
        pred_next    = pred_reg;
        zero_next    = zero_reg;
        level_next   = level_reg;
        neg_next     = neg_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        olevel_next  = olevel_reg;
        opend_next   = opend_reg;
        ostat_next   = ostat_reg;
        s_we         = 1'b0;
        e_we         = 1'b0;
        s_waddr      = ptr_add(shead_reg, scnt_reg);
        e_waddr      = ptr_add(ehead_reg, ecnt_reg);
        s_raddr      = shead_reg;
        e_raddr      = ehead_reg;
        div_dividend_next = div_dividend_reg;
        a_val = '0;
        sum65 = '0;
        res   = '0;
        mag   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    t_next     = in_time;
                    meas_next  = in_meas;
                    ostat_next = ST_OK;
                    olevel_next = '0;
                    unique case (op_t'(in_op))
                        OP_ADD:
                        begin
                            sent_next = sent_reg + {32'd0, in_cnt};
                        end
                        OP_PUSH_STRT:
                        begin
                            if (scnt_reg == CNT_W'(QUEUE_DEPTH))
                                ostat_next = ST_FULL;
                            else
                            begin
                                s_we      = 1'b1;
                                scnt_next = scnt_reg + CNT_W'(1);
                                if (!fseen_reg)
                                begin
                                    fst_next   = in_time;
                                    fseen_next = 1'b1;
                                end
                            end
                        end
                        OP_POP_STRT:
                        begin
                            if (scnt_reg == '0)
                                ostat_next = ST_EMPTY;
                            else
                                scnt_next = scnt_reg - CNT_W'(1);
                        end
                        OP_PUSH_END:
                        begin
                            // ignored until a burst start has been seen
                            if (fseen_reg)
                            begin
                                if (ecnt_reg == CNT_W'(QUEUE_DEPTH))
                                    ostat_next = ST_FULL;
                                else
                                begin
                                    e_we      = 1'b1;
                                    ecnt_next = ecnt_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_POP_END:
                        begin
                            if (ecnt_reg == '0)
                                ostat_next = ST_EMPTY;
                            else
                                ecnt_next = ecnt_reg - CNT_W'(1);
                        end
                        OP_QUERY, OP_MEASURE:
                        begin
                            meas_op_next = (op_t'(in_op) == OP_MEASURE);
                            state_next   = S_RET_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (state_next == S_IDLE)
                    begin
                        ovalid_next = 1'b1;
                        opend_next  = (in_time < fst_next);
                    end
                end
            end
            S_RET_RD:
            begin
                // retire needs a paired start and end entry
                if (scnt_reg != '0 && ecnt_reg != '0)
                    state_next = S_RET_CHK;
                else
                    state_next = S_END_RD;
            end
            S_RET_CHK:
            begin
                if (s_rdata < t_reg)
                begin
                    blanked_next = blanked_reg + {1'b0, s_rdata} - {1'b0, e_rdata};
                    shead_next   = ptr_add(shead_reg, CNT_W'(1));
                    ehead_next   = ptr_add(ehead_reg, CNT_W'(1));
                    scnt_next    = scnt_reg - CNT_W'(1);
                    ecnt_next    = ecnt_reg - CNT_W'(1);
                    s_raddr      = ptr_add(shead_reg, CNT_W'(1));
                    e_raddr      = ptr_add(ehead_reg, CNT_W'(1));
                    state_next   = S_RET_RD;
                end
                else
                    state_next = S_END_RD;
            end
            S_END_RD:
            begin
                state_next = S_END_CHK;
            end
            S_END_CHK:
            begin
                // open blank period ends streaming at the first end entry
                if (ecnt_reg != '0 && t_reg > e_rdata)
                    a_val = {1'b0, e_rdata};
                else
                    a_val = {1'b0, t_reg};
                // negative streaming time counts as zero
                if (!blanked_reg[ACC_W-1] && blanked_reg > a_val)
                    stream_next = '0;
                else
                    stream_next = a_val - blanked_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = S_LVL1;
            end
            S_LVL1:
            begin
                zero_next  = consumed > sent_reg;
                pred_next  = sent_reg - consumed;
                state_next = S_LVL2;
            end
            S_LVL2:
            begin
                if (!bias_reg[ACC_W-1])
                begin
                    sum65 = {1'b0, pred_reg} + {1'b0, bias_reg};
                    res   = sum65[ACC_W] ? {ACC_W{1'b1}} : sum65[ACC_W-1:0];
                end
                else
                begin
                    mag = '0 - bias_reg;
                    res = (mag >= pred_reg) ? '0 : pred_reg - mag;
                end
                if (zero_reg)
                    level_next = '0;
                else if (res[ACC_W-1])
                    level_next = T63_MAX;
                else
                    level_next = res[TIME_W-1:0];
                state_next = S_OUT;
                if (meas_op_reg && meas_reg != '0 && !(t_reg < fst_reg))
                begin
                    if (meas_reg > target_reg)
                    begin
                        div_dividend_next = {31'd0, meas_reg - target_reg};
                        neg_next          = 1'b0;
                        state_next        = S_DIV;
                    end
                    else if ({31'd0, meas_reg} < level_next)
                    begin
                        div_dividend_next = level_next - {31'd0, meas_reg};
                        neg_next          = 1'b1;
                        state_next        = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // saturating bias update
                    if (neg_reg)
                        sum65 = {bias_reg[ACC_W-1], bias_reg} - {2'b00, div_q};
                    else
                        sum65 = {bias_reg[ACC_W-1], bias_reg} + {2'b00, div_q};
                    if (sum65[ACC_W] != sum65[ACC_W-1])
                        bias_next = sum65[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                 : {1'b0, {(ACC_W-1){1'b1}}};
                    else
                        bias_next = sum65[ACC_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    olevel_next = level_reg;
                    opend_next  = (t_reg < fst_reg);
                    ostat_next  = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        mul_start = (state_reg == S_END_CHK);
        div_start = (state_reg == S_LVL2) && (state_next == S_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            scnt_reg    <= '0;
            ecnt_reg    <= '0;
            shead_reg   <= '0;
            ehead_reg   <= '0;
            blanked_reg <= '0;
            fst_reg     <= '0;
            fseen_reg   <= 1'b0;
            sent_reg    <= '0;
            bias_reg    <= '0;
            ovalid_reg  <= 1'b0;
            rate_reg    <= '0;
            target_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            scnt_reg    <= scnt_next;
            ecnt_reg    <= ecnt_next;
            shead_reg   <= shead_next;
            ehead_reg   <= ehead_next;
            blanked_reg <= blanked_next;
            fst_reg     <= fst_next;
            fseen_reg   <= fseen_next;
            sent_reg    <= sent_next;
            bias_reg    <= bias_next;
            ovalid_reg  <= ovalid_next;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_SAMPLE_RATE:  rate_reg   <= cfg_wdata;
                    REG_TARGET_LEVEL: target_reg <= cfg_wdata[CNT32_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meas_op_reg      <= meas_op_next;
        t_reg            <= t_next;
        meas_reg         <= meas_next;
        stream_reg       <= stream_next;
        pred_reg         <= pred_next;
        zero_reg         <= zero_next;
        level_reg        <= level_next;
        neg_reg          <= neg_next;
        olevel_reg       <= olevel_next;
        opend_reg        <= opend_next;
        ostat_reg        <= ostat_next;
        div_dividend_reg <= div_dividend_next;
    end

    tblp_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_start_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (in_time),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    tblp_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_end_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (in_time),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    tblp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (stream_reg),
        .b      (rate_reg),
        .done   (mul_done),
        .result (consumed)
    );

    tblp_div100 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend_next),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {6'd0, ostat_reg, opend_reg, olevel_reg};
endmodule

[tb/sv/tb_tx_buffer_level_predictor_core.sv]
// testbench of the tx buffer level predictor core: directed and random requests
module tb_tx_buffer_level_predictor_core;
    import tblp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // run limit in cycles, well above the slowest correct run
    localparam int CYCLE_LIMIT = 3000000;
    // settle time before a register write and at the end, above the worst request latency
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic [TIME_W-1:0] level;
        logic              pending;
        logic [STAT_W-1:0] status;
    } level_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [RATE_W-1:0]  cfg_wdata;

    // predictor copy of the block state
    logic [RATE_W-1:0]  rate_q;
    logic [31:0]        target_q;
    logic [63:0]        start_times [QUEUE_DEPTH];
    logic [63:0]        end_times [QUEUE_DEPTH];
    int                 start_fill;
    int                 end_fill;
    logic [63:0]        blanked_sum;
    logic [63:0]        first_start;
    logic               first_seen;
    logic [63:0]        sent_sum;
    logic signed [63:0] bias_q;

    level_result_t      level_queue [$];
    int                 mismatches;
    longint             cycles;
    bit                 steady;      // no gaps and no stalls while set
    int                 stall_left;
    logic [63:0]        now_ticks;   // time cursor of the random bursts

    tx_buffer_level_predictor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // saturating signed add to the bias
    function automatic void bias_step(input logic signed [63:0] d);
        logic signed [63:0] sum;
        sum = bias_q + d;
        if (bias_q[63] == d[63] && sum[63] != d[63])
            bias_q = d[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            bias_q = sum;
    endfunction

    // retire past pairs, then level = sent - consumed + bias, clamped
    function automatic logic [TIME_W-1:0] level_now(input logic [63:0] now);
        int          k;
        logic [63:0] partial;
        logic [63:0] a;
        logic [63:0] streaming;
        logic [63:0] consumed;
        logic [63:0] pred;
        logic [63:0] res;
        logic [63:0] mag;
        logic [127:0] prod;
        k = 0;
        while (k < start_fill && k < end_fill && start_times[k] < now)
        begin
            blanked_sum += start_times[k] - end_times[k];
            k++;
        end
        if (k > 0)
        begin
            for (int i = k; i < start_fill; i++)
                start_times[i-k] = start_times[i];
            for (int i = k; i < end_fill; i++)
                end_times[i-k] = end_times[i];
            start_fill -= k;
            end_fill -= k;
        end
        partial = (end_fill > 0 && now > end_times[0]) ? now - end_times[0] : 64'd0;
        a = now - partial;
        // a negative blanked total adds streaming time
        if (!blanked_sum[63])
            streaming = (blanked_sum > a) ? 64'd0 : a - blanked_sum;
        else
            streaming = a - blanked_sum;
        prod = {64'd0, streaming} * {80'd0, rate_q};
        consumed = (prod[127:96] != 0) ? {64{1'b1}} : prod[95:32];
        if (consumed > sent_sum)
            return '0;
        pred = sent_sum - consumed;
        if (!bias_q[63])
        begin
            res = pred + bias_q;
            if (res < pred)
                res = {64{1'b1}};
        end
        else
        begin
            mag = -bias_q;
            res = (mag >= pred) ? 64'd0 : pred - mag;
        end
        return (res > {1'b0, T63_MAX}) ? T63_MAX : res[TIME_W-1:0];
    endfunction

    // apply one accepted request to the predictor state and queue its result
    function automatic void predict_level(input op_t op, input logic [TIME_W-1:0] t,
                                          input logic [31:0] cnt, input logic [31:0] meas);
        level_result_t r;
        logic [63:0]   tt;
        tt = {1'b0, t};
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD: sent_sum += {32'd0, cnt};
            OP_PUSH_STRT:
                if (start_fill >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    start_times[start_fill++] = tt;
                    if (!first_seen)
                    begin
                        first_start = tt;
                        first_seen = 1'b1;
                    end
                end
            OP_POP_STRT:
                if (start_fill == 0)
                    r.status = ST_EMPTY;
                else
                    start_fill--;
            // end edges before the first start are dropped silently
            OP_PUSH_END:
                if (first_seen)
                begin
                    if (end_fill >= QUEUE_DEPTH)
                        r.status = ST_FULL;
                    else
                        end_times[end_fill++] = tt;
                end
            OP_POP_END:
                if (end_fill == 0)
                    r.status = ST_EMPTY;
                else
                    end_fill--;
            OP_QUERY: r.level = level_now(tt);
            OP_MEASURE:
            begin
                r.level = level_now(tt);
                // bias follows one hundredth of the error for a nonzero measure not before the first start
                if (meas != 0 && !(tt < first_start))
                begin
                    if (meas > target_q)
                        bias_step(signed'({32'd0, (meas - target_q) / 32'd100}));
                    else if ({32'd0, meas} < {1'b0, r.level})
                        bias_step(-signed'(({1'b0, r.level} - {32'd0, meas}) / 64'd100));
                end
            end
            default: ;
        endcase
        r.pending = (tt < first_start);
        level_queue = {level_queue, r};
    endfunction

    // one request on the slave side, entered and left at a falling edge
    task automatic send_req(input op_t op, input logic [TIME_W-1:0] t,
                            input logic [31:0] cnt, input logic [31:0] meas);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = steady ? 0 : (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                    : $urandom_range(10, 60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {6'd0, meas, cnt, t, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_level(op, t, cnt, meas);
        @(negedge clk);
    endtask

    // drain all results and let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (level_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [RATE_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SAMPLE_RATE)
            rate_q = v;
        else
            target_q = v[31:0];
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // edge cases of the queues and of an empty state
    task automatic test_queue_edges();
        // end edge before any start is ignored
        send_req(OP_PUSH_END, 63'd100, '0, '0);
        send_req(OP_POP_STRT, '0, '0, '0);
        send_req(OP_POP_END, '0, '0, '0);
        send_req(OP_NONE, T63_MAX, '1, '1);
        send_req(OP_QUERY, '0, '0, '0);
        send_req(OP_MEASURE, T63_MAX, '0, '1);
        send_req(OP_ADD, '0, 32'hFFFF_FFFF, '0);
        // fill both queues past their depth
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_req(OP_PUSH_STRT, 63'(1000 + 100 * i), '0, '0);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_req(OP_PUSH_END, 63'(990 + 100 * i), '0, '0);
        send_req(OP_QUERY, 63'd500, '0, '0);
        send_req(OP_POP_STRT, '0, '0, '0);
        send_req(OP_POP_END, '0, '0, '0);
        // retires every pair
        send_req(OP_QUERY, T63_MAX, '0, '0);
        send_req(OP_MEASURE, 63'd5000, '0, 32'hFFFF_FFFF);
        send_req(OP_MEASURE, 63'd5000, '0, 32'd1);
    endtask

    // well-formed burst traffic on an advancing clock, with a little noise
    task automatic test_random_bursts(input int n, input logic [63:0] base);
        int w;
        now_ticks = base;
        for (int i = 0; i < n; i++)
        begin
            w = $urandom_range(0, 99);
            now_ticks += 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000)
                                                         : $urandom_range(0, 50));
            if (w < 18)
                send_req(OP_ADD, '0, ($urandom_range(0, 9) == 0) ? $urandom
                                                                  : $urandom_range(0, 5000), '0);
            else if (w < 32)
                send_req(OP_PUSH_STRT, 63'(now_ticks + $urandom_range(0, 2000)), '0, '0);
            else if (w < 46)
                send_req(OP_PUSH_END, 63'(now_ticks + $urandom_range(0, 2000)), '0, '0);
            else if (w < 66)
                send_req(OP_QUERY, 63'(now_ticks), '0, '0);
            else if (w < 86)
                send_req(OP_MEASURE, 63'(now_ticks), '0,
                         ($urandom_range(0, 7) == 0) ? 32'd0 :
                         ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20000));
            else if (w < 90)
                send_req(OP_POP_STRT, rand_time(), '0, '0);
            else if (w < 94)
                send_req(OP_POP_END, rand_time(), '0, '0);
            else
                send_req(op_t'($urandom_range(0, 7)), rand_time(), $urandom, $urandom);
        end
    endtask

    // checker: compares each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (level_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                level_result_t e;
                e = level_queue.pop_front();
                if (m_tdata[62:0] !== e.level || m_tdata[63] !== e.pending
                    || m_tdata[65:64] !== e.status || m_tdata[OUT_W-1:66] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: level exp %h got %h, pending exp %b got %b,",
                                  " status exp %0d got %0d"},
                                 e.level, m_tdata[62:0], e.pending, m_tdata[63],
                                 e.status, m_tdata[65:64]);
                end
            end
        end
    end

    // master side back-pressure, mostly short stalls and a few long ones
    always @(negedge clk)
    begin
        int r;
        if (steady)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else if (r < 12)
            begin
                stall_left = $urandom_range(20, 80);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        stall_left = 0;
        steady = 1'b0;
        mismatches = 0;
        cycles = 0;
        rate_q = '0;
        target_q = '0;
        start_fill = 0;
        end_fill = 0;
        blanked_sum = '0;
        first_start = '0;
        first_seen = 1'b0;
        sent_sum = '0;
        bias_q = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_queue_edges();
        write_reg(REG_SAMPLE_RATE, 48'h0001_0000_0000);
        write_reg(REG_TARGET_LEVEL, 48'd3000);
        test_random_bursts(300, 64'd0);
        steady = 1'b1;
        test_random_bursts(150, 64'd5000000);
        steady = 1'b0;
        write_reg(REG_SAMPLE_RATE, {RATE_W{1'b1}});
        write_reg(REG_TARGET_LEVEL, 48'hFFFF_FFFF);
        test_random_bursts(250, {2'b01, 62'd0});
        write_reg(REG_SAMPLE_RATE, 48'd0);
        write_reg(REG_TARGET_LEVEL, 48'd0);
        test_random_bursts(250, 64'd20000000);
        write_reg(REG_SAMPLE_RATE, {16'd0, $urandom});
        write_reg(REG_TARGET_LEVEL, {16'd0, $urandom_range(0, 20000)});
        test_random_bursts(350, 64'd40000000);
        write_reg(REG_SAMPLE_RATE, {16'($urandom_range(0, 65535)), $urandom});
        write_reg(REG_TARGET_LEVEL, {16'd0, $urandom});
        test_random_bursts(300, {1'b0, rand_time()} >> 2);

        wait_idle();
        if (mismatches == 0 && level_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[tx_buffer_level_predictor_core.f]
design/tblp_pkg.sv
design/tblp_ram.sv
design/tblp_mul.sv
design/tblp_div100.sv
design/tx_buffer_level_predictor_core.sv
tb/sv/tb_tx_buffer_level_predictor_core.sv
